// ===== rtl/core/lssa_pkg.sv =====
`default_nettype none

package lssa_pkg;

	localparam int NUM_REGS = 16;
	localparam int SLOT_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_REGS - 1);

	localparam int ID_W = 16;
	localparam int POS_W = 16;
	localparam int COST_W = 32;
	localparam int SLOT_OUT_W = 6;
	localparam int OUTCOME_W = 2;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_ASSIGNED = 2'd0,
		OUT_VICTIM   = 2'd1,
		OUT_IGNORED  = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [POS_W-1:0]         start_point;
		logic [POS_W-1:0]         slot_end;
		logic signed [COST_W-1:0] slot_cost;
		logic                     slot_pinned;
		logic signed [COST_W-1:0] pick_cost;
		logic                     first;
	} scan_req_t;

	typedef struct packed {
		logic expire;
		logic better;
	} scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/linear_scan_slot_allocator_top.sv =====
`default_nettype none

// Linear-scan slot allocator. Each accepted word is one live interval, given in
// order of start point; the block frees every slot whose end is at or before the
// new start, places the interval in the lowest free slot, or, when all slots are
// busy, names a spill victim and ignores further intervals until a word with
// pass_start set. A single compare unit walks the pool one slot per cycle, so an
// interval is scanned across all NUM_REGS slots and then finished in ST_FIN;
// the finish waits for the output register to drain, and an interval ignored
// after a failure skips the scan. The result sits in an output register, so the
// next word is accepted while a result waits.
module linear_scan_slot_allocator_top (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire                                pass_start,
	input  wire  [lssa_pkg::ID_W-1:0]          interval_id,
	input  wire  [lssa_pkg::POS_W-1:0]         start_point,
	input  wire  [lssa_pkg::POS_W-1:0]         end_point,
	input  wire  signed [lssa_pkg::COST_W-1:0] cost,
	input  wire                                pinned,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [lssa_pkg::OUTCOME_W-1:0]     outcome,
	output logic [lssa_pkg::SLOT_OUT_W-1:0]    slot,
	output logic [lssa_pkg::ID_W-1:0]          victim_id
);
	import lssa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q, state_d;

	// slot pool
	logic [NUM_REGS-1:0]      busy_q;
	logic [POS_W-1:0]         end_mem  [NUM_REGS];
	logic signed [COST_W-1:0] cost_mem [NUM_REGS];
	logic                     pin_mem  [NUM_REGS];
	logic [ID_W-1:0]          owner_mem[NUM_REGS];
	logic                     failed_q;

	// latched interval
	logic [ID_W-1:0]          id_q;
	logic [POS_W-1:0]         start_q;
	logic [POS_W-1:0]         end_q;
	logic signed [COST_W-1:0] cost_q;
	logic                     pin_q;
	logic                     ign_q;

	// scan state
	logic [SLOT_W-1:0]        idx_q;
	logic                     free_found_q;
	logic [SLOT_W-1:0]        free_idx_q;
	logic [SLOT_W-1:0]        pick_idx_q;
	logic signed [COST_W-1:0] pick_cost_q;
	logic [ID_W-1:0]          pick_owner_q;

	// output word
	logic                     out_valid_q;
	outcome_t                 outcome_q;
	logic [SLOT_OUT_W-1:0]    slot_q;
	logic [ID_W-1:0]          victim_q;

	logic      accept, out_free, fin_fire, fin_fail, fin_write;
	logic      failed_eff, ign_new, scan_step, busy_after;
	scan_req_t req;
	scan_res_t res;

	assign out_free   = !out_valid_q || out_ready;
	assign fin_fire   = (state_q == ST_FIN) && out_free;
	assign fin_fail   = fin_fire && !ign_q && !free_found_q;
	assign fin_write  = fin_fire && !ign_q && free_found_q;
	assign in_ready   = (state_q == ST_IDLE) || fin_fire;
	assign accept     = in_valid && in_ready;
	assign failed_eff = failed_q || fin_fail;
	assign ign_new    = !pass_start && failed_eff;
	assign scan_step  = (state_q == ST_SCAN);

	assign req.start_point = start_q;
	assign req.slot_end    = end_mem[idx_q];
	assign req.slot_cost   = cost_mem[idx_q];
	assign req.slot_pinned = pin_mem[idx_q];
	assign req.pick_cost   = pick_cost_q;
	assign req.first       = (idx_q == '0);

	lssa_scan_unit u_scan (
		.req (req),
		.res (res)
	);

	assign busy_after = busy_q[idx_q] && !res.expire;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ign_new ? ST_FIN : ST_SCAN;
			end
			ST_SCAN: begin
				if (idx_q == LAST_IDX) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (accept) state_d = ign_new ? ST_FIN : ST_SCAN;
				else if (fin_fire) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			busy_q       <= '0;
			failed_q     <= 1'b0;
			ign_q        <= 1'b0;
			idx_q        <= '0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// a new pass wipes the pool after the finishing word is retired
			if (accept && pass_start) begin
				busy_q   <= '0;
				failed_q <= 1'b0;
			end else begin
				if (fin_write) busy_q[free_idx_q] <= 1'b1;
				if (scan_step && busy_q[idx_q] && res.expire) busy_q[idx_q] <= 1'b0;
				if (fin_fail) failed_q <= 1'b1;
			end
			if (scan_step) begin
				if (!busy_after && !free_found_q) free_found_q <= 1'b1;
				if (idx_q != LAST_IDX) idx_q <= idx_q + 1'b1;
			end
			if (accept) begin
				ign_q        <= ign_new;
				idx_q        <= '0;
				free_found_q <= 1'b0;
			end
			if (fin_fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q    <= interval_id;
			start_q <= start_point;
			end_q   <= end_point;
			cost_q  <= cost;
			pin_q   <= pinned;
		end
		if (scan_step) begin
			if (!busy_after && !free_found_q) free_idx_q <= idx_q;
			if (res.better) begin
				pick_idx_q   <= idx_q;
				pick_cost_q  <= req.slot_cost;
				pick_owner_q <= owner_mem[idx_q];
			end
		end
		if (fin_write) begin
			end_mem[free_idx_q]   <= end_q;
			cost_mem[free_idx_q]  <= cost_q;
			pin_mem[free_idx_q]   <= pin_q;
			owner_mem[free_idx_q] <= id_q;
		end
		if (fin_fire) begin
			if (ign_q) begin
				outcome_q <= OUT_IGNORED;
				slot_q    <= '0;
				victim_q  <= '0;
			end else if (free_found_q) begin
				outcome_q <= OUT_ASSIGNED;
				slot_q    <= SLOT_OUT_W'(free_idx_q);
				victim_q  <= '0;
			end else begin
				outcome_q <= OUT_VICTIM;
				slot_q    <= SLOT_OUT_W'(pick_idx_q);
				victim_q  <= pick_owner_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign outcome   = outcome_q;
	assign slot      = slot_q;
	assign victim_id = victim_q;

	a_accept_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (state_q == ST_IDLE || state_q == ST_FIN))
		else $error("interval taken while a scan is running");

	a_no_ready_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !in_ready)
		else $error("ready raised during scan");

	a_ignored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && outcome == OUT_IGNORED) |-> (slot == '0 && victim_id == '0))
		else $error("ignored result carries slot or victim data");

	a_fail_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_fail && !(accept && pass_start)) |=> failed_q)
		else $error("failure flag not set after victim report");

	a_fin_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire |=> out_valid)
		else $error("finished interval produced no result");

endmodule

`default_nettype wire

// ===== rtl/core/lssa_scan_unit.sv =====
`default_nettype none

module lssa_scan_unit (
	input  var lssa_pkg::scan_req_t req,
	output var lssa_pkg::scan_res_t res
);
	import lssa_pkg::*;

	// slot is released once the new interval starts at or after its end
	assign res.expire = (req.start_point >= req.slot_end);

	// slot 0 always seeds the pick; later slots must be unpinned with a strictly lower cost
	assign res.better = req.first ||
		(!req.slot_pinned && (req.pick_cost > req.slot_cost));

endmodule

`default_nettype wire

// ===== bench/lssa_checker.sv =====
module lssa_checker (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	input  wire                                in_ready,
	input  wire                                pass_start,
	input  wire  [lssa_pkg::ID_W-1:0]          interval_id,
	input  wire  [lssa_pkg::POS_W-1:0]         start_point,
	input  wire  [lssa_pkg::POS_W-1:0]         end_point,
	input  wire  signed [lssa_pkg::COST_W-1:0] cost,
	input  wire                                pinned,
	input  wire                                out_valid,
	input  wire                                out_ready,
	input  wire  [lssa_pkg::OUTCOME_W-1:0]     outcome,
	input  wire  [lssa_pkg::SLOT_OUT_W-1:0]    slot,
	input  wire  [lssa_pkg::ID_W-1:0]          victim_id,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 taken_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import lssa_pkg::*;

	typedef struct packed {
		outcome_t              outcome;
		logic [SLOT_OUT_W-1:0] slot;
		logic [ID_W-1:0]       victim_id;
	} alloc_result_t;

	// pool image; per-slot data is read only while its busy bit is set
	logic [NUM_REGS-1:0]      held_busy = '0;
	logic [POS_W-1:0]         held_end    [NUM_REGS];
	logic signed [COST_W-1:0] held_cost   [NUM_REGS];
	logic                     held_pinned [NUM_REGS];
	logic [ID_W-1:0]          held_owner  [NUM_REGS];
	logic                     pool_failed = 1'b0;

	alloc_result_t awaited_allocs[$];
	int fails = 0;
	int waiting = 0;
	int taken = 0;

	assign fail_count = fails;
	assign pending = waiting;
	assign taken_count = taken;

	function automatic alloc_result_t place_interval(input logic ps,
			input logic [ID_W-1:0] id, input logic [POS_W-1:0] sp,
			input logic [POS_W-1:0] ep, input logic signed [COST_W-1:0] c,
			input logic pin);
		alloc_result_t r;
		int free_idx;
		int pick;
		r = '0;
		r.outcome = OUT_ASSIGNED;
		if (ps) begin
			held_busy = '0;
			pool_failed = 1'b0;
		end
		if (pool_failed) begin
			r.outcome = OUT_IGNORED;
			return r;
		end
		free_idx = -1;
		for (int i = 0; i < NUM_REGS; i++) begin
			// expire first, then the lowest free slot wins
			if (held_busy[i] && sp >= held_end[i])
				held_busy[i] = 1'b0;
			if (!held_busy[i] && free_idx < 0)
				free_idx = i;
		end
		if (free_idx >= 0) begin
			held_busy[free_idx] = 1'b1;
			held_end[free_idx] = ep;
			held_cost[free_idx] = c;
			held_pinned[free_idx] = pin;
			held_owner[free_idx] = id;
			r.slot = SLOT_OUT_W'(free_idx);
			return r;
		end
		// slot 0 is the default pick, pinned or not; ties keep the earlier slot
		pick = 0;
		for (int i = 1; i < NUM_REGS; i++) begin
			if (!held_pinned[i] && held_cost[pick] > held_cost[i])
				pick = i;
		end
		pool_failed = 1'b1;
		r.outcome = OUT_VICTIM;
		r.slot = SLOT_OUT_W'(pick);
		r.victim_id = held_owner[pick];
		return r;
	endfunction

	task automatic flag_field(input string field, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		fails++;
		$error("%s: expected %0h, got %0h", field, exp_v, act_v);
	endtask

	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n) begin
			// drain before fill: a word taken at this edge cannot have its result out yet
			if (out_valid && out_ready) begin
				if (awaited_allocs.size() == 0) begin
					flag_field("outcome (no result pending)", 32'hx, 32'(outcome));
				end else begin
					want = awaited_allocs.pop_front();
					if (outcome !== want.outcome)
						flag_field("outcome", 32'(want.outcome), 32'(outcome));
					if (slot !== want.slot)
						flag_field("slot", 32'(want.slot), 32'(slot));
					if (victim_id !== want.victim_id)
						flag_field("victim_id", 32'(want.victim_id), 32'(victim_id));
				end
			end
			if (in_valid && in_ready) begin
				want = place_interval(pass_start, interval_id, start_point, end_point,
					cost, pinned);
				taken++;
				awaited_allocs.push_back(want);
			end
			waiting = awaited_allocs.size();
		end
	end

endmodule

// ===== bench/tb_linear_scan_slot_allocator_top.sv =====
module tb_linear_scan_slot_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lssa_pkg::*;

	localparam int TARGET_ITEMS = 1400;
	localparam int CYCLE_LIMIT = 1_000_000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     pass_start = 1'b0;
	logic [ID_W-1:0]          interval_id = '0;
	logic [POS_W-1:0]         start_point = '0;
	logic [POS_W-1:0]         end_point = '0;
	logic signed [COST_W-1:0] cost = '0;
	logic                     pinned = 1'b0;
	logic                     out_ready = 1'b0;

	wire                      in_ready;
	wire                      out_valid;
	wire [OUTCOME_W-1:0]      outcome;
	wire [SLOT_OUT_W-1:0]     slot;
	wire [ID_W-1:0]           victim_id;

	int fail_count;
	int pending;
	int taken_count;
	int cycle_count = 0;
	int burst_left = 0;
	int ready_hold = 0;

	linear_scan_slot_allocator_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pass_start  (pass_start),
		.interval_id (interval_id),
		.start_point (start_point),
		.end_point   (end_point),
		.cost        (cost),
		.pinned      (pinned),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.outcome     (outcome),
		.slot        (slot),
		.victim_id   (victim_id)
	);

	lssa_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pass_start  (pass_start),
		.interval_id (interval_id),
		.start_point (start_point),
		.end_point   (end_point),
		.cost        (cost),
		.pinned      (pinned),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.outcome     (outcome),
		.slot        (slot),
		.victim_id   (victim_id),
		.fail_count  (fail_count),
		.pending     (pending),
		.taken_count (taken_count)
	);

	always #5 clk = ~clk;

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// result side: random stalls, with a recurring stretch of steady ready
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			out_ready <= 1'b0;
			ready_hold--;
		end else if (cycle_count % 1000 < 200) begin
			out_ready <= 1'b1;
		end else begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: begin
					out_ready <= 1'b0;
					ready_hold = $urandom_range(0, 3);
				end
				4: begin
					out_ready <= 1'b0;
					ready_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) :
						$urandom_range(4, 15);
				end
				default: out_ready <= 1'b1;
			endcase
		end
	end

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_interval(input logic ps, input logic [ID_W-1:0] id,
			input logic [POS_W-1:0] sp, input logic [POS_W-1:0] ep,
			input logic signed [COST_W-1:0] c, input logic pin);
		int gap;
		int roll;
		roll = $urandom_range(0, 99);
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else if (roll < 55) begin
			gap = 0;
		end else if (roll < 85) begin
			gap = $urandom_range(1, 3);
		end else if (roll < 96) begin
			gap = $urandom_range(4, 15);
		end else if (roll < 98) begin
			gap = $urandom_range(20, 80);
		end else begin
			gap = 0;
			burst_left = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pass_start <= ps;
		interval_id <= id;
		start_point <= sp;
		end_point <= ep;
		cost <= c;
		pinned <= pin;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	function automatic logic signed [COST_W-1:0] pick_cost(input int mode);
		case (mode)
			0: return COST_W'(int'($urandom_range(0, 8)) - 4);
			1: return $urandom;
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
		endcase
	endfunction

	initial begin
		logic [POS_W-1:0]         pos;
		logic [POS_W-1:0]         ep;
		logic signed [COST_W-1:0] c;
		logic                     pin;
		logic [ID_W-1:0]          id;
		int n;
		int step_max;
		int life_max;
		int pin_mode;
		int cost_mode;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill the pool: slot 0 pinned and priciest, slot 1 pinned and cheapest,
		// slots 2 and 3 tie on cost so the earlier one must be named
		for (int i = 0; i < NUM_REGS; i++) begin
			id = (i == 0) ? 16'h0000 : (i == NUM_REGS - 1) ? 16'hFFFF : ID_W'(16'h1000 + i);
			case (i)
				0: begin c = 32'sh7FFF_FFFF; pin = 1'b1; end
				1: begin c = 32'sh8000_0000; pin = 1'b1; end
				2, 3: begin c = 32'sd5; pin = 1'b0; end
				default: begin c = COST_W'(1000 + i); pin = i[0]; end
			endcase
			send_interval(i == 0, id, POS_W'(i), 16'hFFFF, c, pin);
		end
		// pool full: victim, then ignored until the next pass
		send_interval(1'b0, 16'hABCD, 16'd20, 16'hFFFF, 32'sd0, 1'b0);
		send_interval(1'b0, 16'h1234, 16'd21, 16'd40, 32'sd7, 1'b0);
		// end below start, freed by a later start at its end
		send_interval(1'b1, 16'h5555, 16'd200, 16'd100, -32'sd1, 1'b0);
		send_interval(1'b0, 16'hAAAA, 16'd100, 16'd300, 32'sd1, 1'b1);
		send_interval(1'b0, 16'h0001, 16'hFFFF, 16'h0000, 32'sd0, 1'b0);
		// every slot but slot 0 pinned: the default pick must stand
		for (int i = 0; i < NUM_REGS + 1; i++)
			send_interval(i == 0, ID_W'(16'h2000 + i), 16'd0, 16'd9, -32'sd100, i != 0);

		while (taken_count < TARGET_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: arbitrary fields, rare pass starts
				n = $urandom_range(1, 8);
				for (int j = 0; j < n; j++)
					send_interval($urandom_range(0, 7) == 0, ID_W'($urandom),
						POS_W'($urandom), POS_W'($urandom), COST_W'($urandom),
						1'($urandom_range(0, 1)));
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(2, 40);
				pos = POS_W'($urandom);
				case ($urandom_range(0, 3))
					0: step_max = 0;
					1: step_max = 2;
					2: step_max = 16;
					default: step_max = 256;
				endcase
				case ($urandom_range(0, 3))
					0: life_max = 8;
					1: life_max = 128;
					2: life_max = 4096;
					default: life_max = 65535;
				endcase
				pin_mode = $urandom_range(0, 3);
				cost_mode = $urandom_range(0, 2);
				for (int j = 0; j < n && taken_count < TARGET_ITEMS; j++) begin
					if ($urandom_range(0, 15) == 0)
						ep = pos - POS_W'($urandom_range(1, 64));
					else
						ep = pos + POS_W'($urandom_range(0, life_max));
					case (pin_mode)
						0: pin = 1'b0;
						3: pin = 1'b1;
						default: pin = ($urandom_range(0, 3) == 0);
					endcase
					send_interval(j == 0, ID_W'($urandom), pos, ep, pick_cost(cost_mode), pin);
					// mostly ascending starts, now and then out of order
					if ($urandom_range(0, 29) == 0)
						pos = POS_W'($urandom);
					else
						pos = pos + POS_W'($urandom_range(0, step_max));
				end
			end
		end
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (NUM_REGS + 8) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
